// File: sv/lasc_pkg.sv
`default_nettype none
package lasc_pkg;

    // request kinds carried in the action field
    typedef enum logic [1:0] {
        ACT_SEND    = 2'd0,
        ACT_RECEIVE = 2'd1,
        ACT_TIMEOUT = 2'd2
    } action_t;

    // verdict codes of a result word
    typedef enum logic [3:0] {
        VERDICT_NONE        = 4'd0,
        VERDICT_SHORT       = 4'd1,
        VERDICT_CRC         = 4'd2,
        VERDICT_STALE       = 4'd3,
        VERDICT_DUPLICATE   = 4'd4,
        VERDICT_SINGLE      = 4'd5,
        VERDICT_DOUBLE      = 4'd6,
        VERDICT_SECOND_HALF = 4'd7,
        VERDICT_MALFORMED   = 4'd8
    } verdict_t;

    // configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT_TICKS     = 2'd0;
    localparam logic [1:0] CFG_RESEND_STEP_TICKS = 2'd1;

    localparam logic [15:0] TIMEOUT_TICKS_RESET     = 16'd60;
    localparam logic [15:0] RESEND_STEP_TICKS_RESET = 16'd4;

    // ring and header constants
    localparam logic [31:0] RING_HIGH_MASK = 32'hffffff00;
    localparam logic [7:0]  STALE_WINDOW   = 8'd32;
    localparam logic [31:0] SEQ_SPAN       = 32'd256;
    localparam logic [10:0] MIN_FRAME      = 11'd5;
    localparam logic [10:0] SINGLE_OFFSET  = 11'd3;
    localparam logic [10:0] DOUBLE_OFFSET  = 11'd5;
    localparam logic [10:0] DOUBLE_HEADER  = 11'd7;

    // one accepted input word
    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  peer;
        logic [31:0] now;
        logic [10:0] frame_length;
        logic        crc_ok;
        logic [7:0]  rx_seq_byte;
        logic [7:0]  rx_flags_byte;
        logic [7:0]  rx_ack_byte;
        logic [10:0] rx_first_length;
    } item_t;

    // one result word
    typedef struct packed {
        logic [3:0]  verdict;
        logic [10:0] first_offset;
        logic [10:0] first_length;
        logic [10:0] second_offset;
        logic [10:0] second_length;
        logic        tx_valid;
        logic        tx_double;
        logic [7:0]  tx_seq_byte;
        logic [7:0]  tx_flags_byte;
        logic [7:0]  tx_ack_byte;
    } result_t;

endpackage
`default_nettype wire

// File: sv/link_arq_sequence_controller.sv
// path: an accepted input word goes into the input register, then its result into the result
//   register; the per-peer state is read and written in between
// throughput: one word per cycle unless the result stalls, which holds the input register
// reset: aresetn synchronous active low; clears all per-peer state to zero,
//   timeout_ticks to 60, resend_step_ticks to 4 and both valid flags
`default_nettype none
module link_arq_sequence_controller
    import lasc_pkg::*;
#(
    parameter int PEERS           = 16,
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // input channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [3:0]  s_peer,
    input  wire logic [31:0] s_now,
    input  wire logic [10:0] s_frame_length,
    input  wire logic        s_crc_ok,
    input  wire logic [7:0]  s_rx_seq_byte,
    input  wire logic [7:0]  s_rx_flags_byte,
    input  wire logic [7:0]  s_rx_ack_byte,
    input  wire logic [10:0] s_rx_first_length,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_verdict,
    output logic [10:0]      m_first_offset,
    output logic [10:0]      m_first_length,
    output logic [10:0]      m_second_offset,
    output logic [10:0]      m_second_length,
    output logic             m_tx_valid,
    output logic             m_tx_double,
    output logic [7:0]       m_tx_seq_byte,
    output logic [7:0]       m_tx_flags_byte,
    output logic [7:0]       m_tx_ack_byte
);

    localparam int PEER_W = $clog2(PEERS);

    // configuration registers
    logic [15:0] timeout_ticks_reg;
    logic [15:0] resend_step_ticks_reg;

    // per-peer state
    logic [7:0]  rx_expected_reg    [PEERS];
    logic [31:0] tx_place_reg       [PEERS];
    logic [31:0] tx_end_reg         [PEERS];
    logic [2:0]  error_tag_reg      [PEERS];
    logic [2:0]  fix_tag_reg        [PEERS];
    logic [2:0]  resend_tag_reg     [PEERS];
    logic [31:0] last_send_tick_reg [PEERS];

    // pipeline registers
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    logic    result_valid_reg;

    logic advance;
    logic in_range;
    logic [PEER_W-1:0] peer_idx;

    // current state of the addressed peer
    logic [7:0]  rxe;
    logic [31:0] place;
    logic [31:0] endv;
    logic [2:0]  etag;
    logic [2:0]  ftag;
    logic [2:0]  rtag;
    logic [31:0] lst;

    // next state of the addressed peer
    logic [7:0]  rx_expected_next;
    logic [31:0] tx_place_next;
    logic [31:0] tx_end_next;
    logic [2:0]  error_tag_next;
    logic [2:0]  fix_tag_next;
    logic [2:0]  resend_tag_next;
    logic [31:0] last_send_tick_next;
    result_t     result_next;

    // receive path terms
    logic        rx_double;
    logic [31:0] rewind_place;
    logic [7:0]  seq_distance;
    logic        double_too_short;
    logic [10:0] second_part_length;

    // timeout path terms
    logic [31:0] lst_clamped;
    logic [32:0] deadline;
    logic [32:0] backoff_sum;
    logic        timeout_fire;

    // transmit header terms
    logic        emit_go;
    logic [31:0] emit_place;
    logic [31:0] emit_end;
    logic        emit_double;

    // handshakes
    assign advance   = item_valid_reg && (!result_valid_reg || m_ready);
    assign s_ready   = !item_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // peer lookup
    assign in_range = ({28'd0, item_reg.peer} < 32'(PEERS));
    assign peer_idx = in_range ? PEER_W'(item_reg.peer) : '0;

    assign rxe   = rx_expected_reg[peer_idx];
    assign place = tx_place_reg[peer_idx];
    assign endv  = tx_end_reg[peer_idx];
    assign etag  = error_tag_reg[peer_idx];
    assign ftag  = fix_tag_reg[peer_idx];
    assign rtag  = resend_tag_reg[peer_idx];
    assign lst   = last_send_tick_reg[peer_idx];

    // fixed receive terms
    assign rx_double        = item_reg.rx_flags_byte[7];
    assign seq_distance     = rxe - item_reg.rx_seq_byte;
    assign double_too_short = ({1'b0, item_reg.frame_length}
                               < ({1'b0, item_reg.rx_first_length} + {1'b0, DOUBLE_HEADER}));
    assign second_part_length = item_reg.frame_length - item_reg.rx_first_length
                                - DOUBLE_HEADER;

    // rewind place from the peer's acknowledge byte
    always_comb begin
        rewind_place = (endv & RING_HIGH_MASK) + {24'd0, item_reg.rx_ack_byte};
        if ($signed(rewind_place) > $signed(endv)) begin
            rewind_place = rewind_place - SEQ_SPAN;
        end
    end

    // fixed timeout terms
    assign lst_clamped  = (item_reg.now < lst) ? item_reg.now : lst;
    assign deadline     = {1'b0, lst_clamped} + {17'd0, timeout_ticks_reg};
    assign backoff_sum  = {1'b0, lst_clamped} + {17'd0, resend_step_ticks_reg};
    assign timeout_fire = ({1'b0, item_reg.now} > deadline);

    // action logic and state update
    always_comb begin
        rx_expected_next    = rxe;
        tx_place_next       = place;
        tx_end_next         = endv;
        error_tag_next      = etag;
        fix_tag_next        = ftag;
        resend_tag_next     = rtag;
        last_send_tick_next = lst;
        result_next         = '0;
        result_next.verdict = VERDICT_NONE;
        emit_go             = 1'b0;
        emit_place          = place;
        emit_end            = endv;
        emit_double         = 1'b0;

        if (in_range) begin
            case (action_t'(item_reg.action))
                ACT_SEND: begin
                    tx_end_next         = endv + 32'd1;
                    last_send_tick_next = item_reg.now;
                    emit_go             = 1'b1;
                    emit_end            = endv + 32'd1;
                end
                ACT_RECEIVE: begin
                    if (item_reg.frame_length < MIN_FRAME) begin
                        result_next.verdict = VERDICT_SHORT;
                    end else if ({21'd0, item_reg.frame_length} > 32'(MAX_FRAME_BYTES)) begin
                        result_next.verdict = VERDICT_MALFORMED;
                    end else if (!item_reg.crc_ok) begin
                        error_tag_next      = ftag + 3'd1;
                        result_next.verdict = VERDICT_CRC;
                    end else begin
                        fix_tag_next = item_reg.rx_flags_byte[5:3];
                        if (item_reg.rx_flags_byte[2:0] != rtag) begin
                            resend_tag_next = rtag + 3'd1;
                            tx_place_next   = rewind_place;
                        end
                        if (item_reg.rx_seq_byte != rxe) begin
                            if (seq_distance > STALE_WINDOW) begin
                                error_tag_next      = item_reg.rx_flags_byte[5:3] + 3'd1;
                                result_next.verdict = VERDICT_STALE;
                            end else if (rx_double
                                         && (item_reg.rx_seq_byte + 8'd1) == rxe) begin
                                if (double_too_short) begin
                                    result_next.verdict = VERDICT_MALFORMED;
                                end else begin
                                    result_next.verdict      = VERDICT_SECOND_HALF;
                                    result_next.first_offset = item_reg.rx_first_length
                                                               + DOUBLE_OFFSET;
                                    result_next.first_length = second_part_length;
                                    rx_expected_next         = rxe + 8'd1;
                                end
                            end else begin
                                result_next.verdict = VERDICT_DUPLICATE;
                            end
                        end else if (!rx_double) begin
                            result_next.verdict      = VERDICT_SINGLE;
                            result_next.first_offset = SINGLE_OFFSET;
                            result_next.first_length = item_reg.frame_length - MIN_FRAME;
                            rx_expected_next         = rxe + 8'd1;
                        end else if (double_too_short) begin
                            result_next.verdict = VERDICT_MALFORMED;
                        end else begin
                            result_next.verdict       = VERDICT_DOUBLE;
                            result_next.first_offset  = DOUBLE_OFFSET;
                            result_next.first_length  = item_reg.rx_first_length;
                            result_next.second_offset = item_reg.rx_first_length
                                                        + DOUBLE_OFFSET;
                            result_next.second_length = second_part_length;
                            rx_expected_next          = rxe + 8'd2;
                        end
                    end
                end
                ACT_TIMEOUT: begin
                    last_send_tick_next = lst_clamped;
                    if (timeout_fire) begin
                        error_tag_next = ftag + 3'd1;
                        emit_go        = 1'b1;
                        if (place == endv && !place[31] && place != 32'd0) begin
                            emit_place          = place - 32'd1;
                            last_send_tick_next = item_reg.now;
                        end else begin
                            last_send_tick_next = backoff_sum[32] ? '1 : backoff_sum[31:0];
                        end
                    end
                end
                default: begin
                    result_next.verdict = VERDICT_NONE;
                end
            endcase
        end

        // transmit header of the next single or double
        if (emit_go && emit_place != emit_end) begin
            emit_double               = (emit_place + 32'd1) != emit_end;
            result_next.tx_valid      = 1'b1;
            result_next.tx_double     = emit_double;
            result_next.tx_seq_byte   = emit_place[7:0];
            result_next.tx_flags_byte = {emit_double, 1'b0, resend_tag_next, error_tag_next};
            result_next.tx_ack_byte   = rxe;
            tx_place_next             = emit_place + (emit_double ? 32'd2 : 32'd1);
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ticks_reg     <= TIMEOUT_TICKS_RESET;
            resend_step_ticks_reg <= RESEND_STEP_TICKS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TIMEOUT_TICKS:     timeout_ticks_reg     <= cfg_data;
                CFG_RESEND_STEP_TICKS: resend_step_ticks_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // per-peer state write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PEERS; i++) begin
                rx_expected_reg[i]    <= '0;
                tx_place_reg[i]       <= '0;
                tx_end_reg[i]         <= '0;
                error_tag_reg[i]      <= '0;
                fix_tag_reg[i]        <= '0;
                resend_tag_reg[i]     <= '0;
                last_send_tick_reg[i] <= '0;
            end
        end else if (advance && in_range) begin
            rx_expected_reg[peer_idx]    <= rx_expected_next;
            tx_place_reg[peer_idx]       <= tx_place_next;
            tx_end_reg[peer_idx]         <= tx_end_next;
            error_tag_reg[peer_idx]      <= error_tag_next;
            fix_tag_reg[peer_idx]        <= fix_tag_next;
            resend_tag_reg[peer_idx]     <= resend_tag_next;
            last_send_tick_reg[peer_idx] <= last_send_tick_next;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.action          <= s_action;
            item_reg.peer            <= s_peer;
            item_reg.now             <= s_now;
            item_reg.frame_length    <= s_frame_length;
            item_reg.crc_ok          <= s_crc_ok;
            item_reg.rx_seq_byte     <= s_rx_seq_byte;
            item_reg.rx_flags_byte   <= s_rx_flags_byte;
            item_reg.rx_ack_byte     <= s_rx_ack_byte;
            item_reg.rx_first_length <= s_rx_first_length;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            result_valid_reg <= 1'b0;
        end else if (advance) begin
            result_valid_reg <= 1'b1;
        end else if (m_ready) begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid         = result_valid_reg;
    assign m_verdict       = result_reg.verdict;
    assign m_first_offset  = result_reg.first_offset;
    assign m_first_length  = result_reg.first_length;
    assign m_second_offset = result_reg.second_offset;
    assign m_second_length = result_reg.second_length;
    assign m_tx_valid      = result_reg.tx_valid;
    assign m_tx_double     = result_reg.tx_double;
    assign m_tx_seq_byte   = result_reg.tx_seq_byte;
    assign m_tx_flags_byte = result_reg.tx_flags_byte;
    assign m_tx_ack_byte   = result_reg.tx_ack_byte;

endmodule
`default_nettype wire

// File: sv/lasc_checker.sv
`default_nettype none
module lasc_checker
    import lasc_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [3:0]  m_verdict,
    input wire logic [10:0] m_first_offset,
    input wire logic [10:0] m_first_length,
    input wire logic [10:0] m_second_offset,
    input wire logic [10:0] m_second_length,
    input wire logic        m_tx_valid,
    input wire logic        m_tx_double,
    input wire logic [7:0]  m_tx_seq_byte,
    input wire logic [7:0]  m_tx_flags_byte,
    input wire logic [7:0]  m_tx_ack_byte
);

    // no transmit means an all-zero transmit header
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tx_valid |-> !m_tx_double && m_tx_seq_byte == 8'd0
            && m_tx_flags_byte == 8'd0 && m_tx_ack_byte == 8'd0)
        else $error("transmit fields set without a transmit");

    // the double bit of the header agrees with tx_double
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tx_valid |-> m_tx_flags_byte[7] == m_tx_double
            && !m_tx_flags_byte[6])
        else $error("transmit flags disagree with tx_double");

    // a double delivery places the second payload right after the first
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_verdict == VERDICT_DOUBLE |-> m_first_offset == DOUBLE_OFFSET
            && m_second_offset == m_first_length + DOUBLE_OFFSET)
        else $error("double payload offsets inconsistent");

    // only a double delivery carries a second payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_verdict != VERDICT_DOUBLE |-> m_second_offset == 11'd0
            && m_second_length == 11'd0)
        else $error("second payload without a double delivery");

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_verdict) && $stable(m_first_length)
            && $stable(m_tx_seq_byte))
        else $error("result word changed while stalled");

endmodule

bind link_arq_sequence_controller lasc_checker u_lasc_checker (.*);
`default_nettype wire

// File: sim/link_arq_sequence_controller_tb.sv
module link_arq_sequence_controller_tb
    import lasc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PEER_COUNT = 16;
    localparam int MAX_FRAME = 2048;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // clock and reset
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    always #2 aclk = ~aclk;

    // block ports
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_TIMEOUT_TICKS;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = ACT_SEND;
    logic [3:0]  s_peer = '0;
    logic [31:0] s_now = '0;
    logic [10:0] s_frame_length = '0;
    logic        s_crc_ok = 1'b0;
    logic [7:0]  s_rx_seq_byte = '0;
    logic [7:0]  s_rx_flags_byte = '0;
    logic [7:0]  s_rx_ack_byte = '0;
    logic [10:0] s_rx_first_length = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_verdict;
    logic [10:0] m_first_offset;
    logic [10:0] m_first_length;
    logic [10:0] m_second_offset;
    logic [10:0] m_second_length;
    logic        m_tx_valid;
    logic        m_tx_double;
    logic [7:0]  m_tx_seq_byte;
    logic [7:0]  m_tx_flags_byte;
    logic [7:0]  m_tx_ack_byte;

    link_arq_sequence_controller #(
        .PEERS(PEER_COUNT),
        .MAX_FRAME_BYTES(MAX_FRAME)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_action(s_action),
        .s_peer(s_peer),
        .s_now(s_now),
        .s_frame_length(s_frame_length),
        .s_crc_ok(s_crc_ok),
        .s_rx_seq_byte(s_rx_seq_byte),
        .s_rx_flags_byte(s_rx_flags_byte),
        .s_rx_ack_byte(s_rx_ack_byte),
        .s_rx_first_length(s_rx_first_length),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_verdict(m_verdict),
        .m_first_offset(m_first_offset),
        .m_first_length(m_first_length),
        .m_second_offset(m_second_offset),
        .m_second_length(m_second_length),
        .m_tx_valid(m_tx_valid),
        .m_tx_double(m_tx_double),
        .m_tx_seq_byte(m_tx_seq_byte),
        .m_tx_flags_byte(m_tx_flags_byte),
        .m_tx_ack_byte(m_tx_ack_byte)
    );

    // per-peer retransmit state as the block should hold it
    logic [7:0]  rx_next   [PEER_COUNT];
    logic [31:0] place     [PEER_COUNT];
    logic [31:0] send_end  [PEER_COUNT];
    logic [2:0]  err_tag   [PEER_COUNT];
    logic [2:0]  fixed_tag [PEER_COUNT];
    logic [2:0]  resend    [PEER_COUNT];
    logic [31:0] last_sent [PEER_COUNT];
    logic [15:0] timeout_setting = TIMEOUT_TICKS_RESET;
    logic [15:0] backoff_setting = RESEND_STEP_TICKS_RESET;

    // stimulus side view of each peer's receive sequence and resend tag
    logic [7:0]  gen_expected [PEER_COUNT];
    logic [2:0]  gen_resend   [PEER_COUNT];
    logic [31:0] gen_now = '0;

    item_t   pending_requests [$];
    result_t awaited_results [$];
    item_t   offered;
    result_t awaited;
    int      queued_total = 0;
    int      accepted_total = 0;
    int      results_checked = 0;
    int      mismatch_count = 0;
    int      sender_gap = 0;
    int      receiver_stall = 0;
    int      hold_left = 0;
    bit      hold_done = 1'b0;
    bit      steady = 1'b0;

    // header of the next transmit, advancing the transmit place
    function automatic result_t add_transmit(logic [3:0] p, result_t r);
        logic two;
        if (place[p] != send_end[p]) begin
            two = (place[p] + 32'd1) != send_end[p];
            r.tx_valid = 1'b1;
            r.tx_double = two;
            r.tx_seq_byte = place[p][7:0];
            r.tx_flags_byte = {two, 1'b0, resend[p], err_tag[p]};
            r.tx_ack_byte = rx_next[p];
            place[p] = place[p] + (two ? 32'd2 : 32'd1);
        end
        return r;
    endfunction

    // expected result word for one request word, updating the peer state
    function automatic result_t predict_result(item_t w);
        result_t r;
        logic [3:0] p;
        logic [7:0] seq_gap;
        logic [31:0] np;
        logic [32:0] stretched;
        int flen;
        int l1;
        logic dbl;
        r = '0;
        p = w.peer;
        flen = int'(w.frame_length);
        l1 = int'(w.rx_first_length);
        dbl = w.rx_flags_byte[7];
        case (w.action)
            ACT_SEND: begin
                send_end[p] = send_end[p] + 32'd1;
                last_sent[p] = w.now;
                r = add_transmit(p, r);
            end
            ACT_RECEIVE: begin
                if (flen < MIN_FRAME) begin
                    r.verdict = VERDICT_SHORT;
                end else if (flen > MAX_FRAME) begin
                    r.verdict = VERDICT_MALFORMED;
                end else if (!w.crc_ok) begin
                    err_tag[p] = fixed_tag[p] + 3'd1;
                    r.verdict = VERDICT_CRC;
                end else begin
                    fixed_tag[p] = w.rx_flags_byte[5:3];
                    // a changed resend tag rewinds to the acknowledged slot
                    if (w.rx_flags_byte[2:0] != resend[p]) begin
                        resend[p] = resend[p] + 3'd1;
                        np = (send_end[p] & RING_HIGH_MASK) + {24'd0, w.rx_ack_byte};
                        if ($signed(np) > $signed(send_end[p]))
                            np = np - SEQ_SPAN;
                        place[p] = np;
                    end
                    // sequence check
                    seq_gap = rx_next[p] - w.rx_seq_byte;
                    if (seq_gap > STALE_WINDOW) begin
                        err_tag[p] = fixed_tag[p] + 3'd1;
                        r.verdict = VERDICT_STALE;
                    end else if (seq_gap == 8'd1 && dbl) begin
                        if (flen < l1 + DOUBLE_HEADER) begin
                            r.verdict = VERDICT_MALFORMED;
                        end else begin
                            r.verdict = VERDICT_SECOND_HALF;
                            r.first_offset = 11'(l1) + DOUBLE_OFFSET;
                            r.first_length = 11'(flen) - DOUBLE_HEADER - 11'(l1);
                            rx_next[p] = rx_next[p] + 8'd1;
                        end
                    end else if (seq_gap != 8'd0) begin
                        r.verdict = VERDICT_DUPLICATE;
                    end else if (!dbl) begin
                        r.verdict = VERDICT_SINGLE;
                        r.first_offset = SINGLE_OFFSET;
                        r.first_length = 11'(flen) - MIN_FRAME;
                        rx_next[p] = rx_next[p] + 8'd1;
                    end else if (flen < l1 + DOUBLE_HEADER) begin
                        r.verdict = VERDICT_MALFORMED;
                    end else begin
                        r.verdict = VERDICT_DOUBLE;
                        r.first_offset = DOUBLE_OFFSET;
                        r.first_length = 11'(l1);
                        r.second_offset = 11'(l1) + DOUBLE_OFFSET;
                        r.second_length = 11'(flen) - DOUBLE_HEADER - 11'(l1);
                        rx_next[p] = rx_next[p] + 8'd2;
                    end
                end
            end
            ACT_TIMEOUT: begin
                if (w.now < last_sent[p])
                    last_sent[p] = w.now;
                if ({1'b0, w.now} > {1'b0, last_sent[p]} + {17'd0, timeout_setting}) begin
                    err_tag[p] = fixed_tag[p] + 3'd1;
                    // rewind one packet, or back off with saturation
                    if (place[p] == send_end[p] && $signed(place[p]) > 32'sd0) begin
                        place[p] = place[p] - 32'd1;
                        last_sent[p] = w.now;
                    end else begin
                        stretched = {1'b0, last_sent[p]} + {17'd0, backoff_setting};
                        last_sent[p] = stretched[32] ? 32'hFFFF_FFFF : stretched[31:0];
                    end
                    r = add_transmit(p, r);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("%0t ns: mismatch in %s: got %0h, want %0h", $time, what, got, want);
    endtask

    task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // queue a request word and follow the peer's receive sequence
    task automatic queue_request(item_t w);
        logic [7:0] seq_gap;
        logic fits;
        if (w.action == ACT_RECEIVE && w.frame_length >= MIN_FRAME && w.crc_ok) begin
            fits = int'(w.frame_length) >= int'(w.rx_first_length) + 7;
            if (w.rx_flags_byte[2:0] != gen_resend[w.peer])
                gen_resend[w.peer] = gen_resend[w.peer] + 3'd1;
            seq_gap = gen_expected[w.peer] - w.rx_seq_byte;
            if (seq_gap == 8'd0 && !w.rx_flags_byte[7])
                gen_expected[w.peer] = gen_expected[w.peer] + 8'd1;
            else if (seq_gap == 8'd0 && fits)
                gen_expected[w.peer] = gen_expected[w.peer] + 8'd2;
            else if (seq_gap == 8'd1 && w.rx_flags_byte[7] && fits)
                gen_expected[w.peer] = gen_expected[w.peer] + 8'd1;
        end
        pending_requests.push_back(w);
        queued_total++;
    endtask

    task automatic push_plain(logic [1:0] act, logic [3:0] peer, logic [31:0] now);
        queue_request({act, peer, now, 11'd0, 1'b0, 8'd0, 8'd0, 8'd0, 11'd0});
    endtask

    task automatic push_header(logic [3:0] peer, logic [10:0] flen, logic crc,
                               logic [7:0] seq, logic [7:0] flags, logic [7:0] ack,
                               logic [10:0] l1);
        queue_request({ACT_RECEIVE, peer, gen_now, flen, crc, seq, flags, ack, l1});
    endtask

    // random request: mostly in-sequence frames, plus broken ones and noise
    function automatic item_t random_request();
        item_t w;
        int pick;
        int l1;
        int room;
        logic [7:0] behind;
        w = item_t'({$urandom(), $urandom(), $urandom()});
        pick = $urandom_range(0, 31);
        if (pick == 0)
            gen_now = $urandom();
        else if (pick < 3)
            gen_now = gen_now + $urandom_range(0, 200000);
        else
            gen_now = gen_now + $urandom_range(0, 40);
        w.now = gen_now;
        if ($urandom_range(0, 3) == 0)
            w.peer = 4'($urandom_range(0, 15));
        else
            w.peer = 4'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 33)
            w.action = ACT_SEND;
        else if (pick < 83)
            w.action = ACT_RECEIVE;
        else if (pick < 96)
            w.action = ACT_TIMEOUT;
        else
            w.action = ACT_UNUSED;
        if (w.action == ACT_RECEIVE) begin
            pick = $urandom_range(0, 99);
            if (pick < 96) begin
                w.crc_ok = 1'b1;
                w.rx_seq_byte = gen_expected[w.peer];
                if ($urandom_range(0, 3) == 0)
                    w.rx_flags_byte[2:0] = gen_resend[w.peer] + 3'd1;
                else
                    w.rx_flags_byte[2:0] = gen_resend[w.peer];
                w.rx_flags_byte[7] = (pick >= 62 && pick < 70) || pick >= 92 ||
                                     $urandom_range(0, 9) < 4;
                l1 = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2040)
                                                  : $urandom_range(0, 200);
                w.rx_first_length = 11'(l1);
                room = 2040 - l1;
                if (w.rx_flags_byte[7])
                    w.frame_length = 11'(l1 + 7 + $urandom_range(0, room < 200 ? room : 200));
                else if ($urandom_range(0, 15) == 0)
                    w.frame_length = 11'($urandom_range(5, 2047));
                else
                    w.frame_length = 11'($urandom_range(5, 300));
                // break the well-formed frame in one way
                if (pick >= 92) begin
                    w.frame_length = 11'($urandom_range(5, l1 + 6));
                end else if (pick >= 88) begin
                    w.frame_length = 11'($urandom_range(0, 4));
                end else if (pick >= 82) begin
                    w.crc_ok = 1'b0;
                end else if (pick >= 76) begin
                    behind = 8'($urandom_range(33, 255));
                    w.rx_seq_byte = w.rx_seq_byte - behind;
                end else if (pick >= 70) begin
                    behind = 8'($urandom_range(1, 32));
                    w.rx_seq_byte = w.rx_seq_byte - behind;
                end else if (pick >= 62) begin
                    w.rx_seq_byte = w.rx_seq_byte - 8'd1;
                end
            end
        end
        return w;
    endfunction

    task automatic write_register(logic [1:0] index, logic [15:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == CFG_TIMEOUT_TICKS)
            timeout_setting = data;
        else if (index == CFG_RESEND_STEP_TICKS)
            backoff_setting = data;
    endtask

    // wait until every queued word is through and answered
    task automatic wait_drained();
        do @(posedge aclk);
        while (accepted_total != queued_total || awaited_results.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase(int count);
        repeat (count) queue_request(random_request());
        wait_drained();
    endtask

    // request word driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            sender_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                awaited_results.push_back(predict_result(offered));
                accepted_total++;
            end
            if (!s_valid || s_ready) begin
                if (sender_gap != 0) begin
                    sender_gap--;
                    s_valid <= 1'b0;
                end else if (!steady && $urandom_range(0, 7) == 0) begin
                    sender_gap = $urandom_range(0, 5);
                    s_valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    offered = pending_requests.pop_front();
                    {s_action, s_peer, s_now, s_frame_length, s_crc_ok, s_rx_seq_byte,
                     s_rx_flags_byte, s_rx_ack_byte, s_rx_first_length} <= offered;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result word monitor and receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            receiver_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result word with nothing awaited", 0, 0);
                end else begin
                    awaited = awaited_results.pop_front();
                    compare_field("verdict", 32'(m_verdict), 32'(awaited.verdict));
                    compare_field("first_offset", 32'(m_first_offset),
                                  32'(awaited.first_offset));
                    compare_field("first_length", 32'(m_first_length),
                                  32'(awaited.first_length));
                    compare_field("second_offset", 32'(m_second_offset),
                                  32'(awaited.second_offset));
                    compare_field("second_length", 32'(m_second_length),
                                  32'(awaited.second_length));
                    compare_field("tx_valid", 32'(m_tx_valid), 32'(awaited.tx_valid));
                    compare_field("tx_double", 32'(m_tx_double), 32'(awaited.tx_double));
                    compare_field("tx_seq_byte", 32'(m_tx_seq_byte),
                                  32'(awaited.tx_seq_byte));
                    compare_field("tx_flags_byte", 32'(m_tx_flags_byte),
                                  32'(awaited.tx_flags_byte));
                    compare_field("tx_ack_byte", 32'(m_tx_ack_byte),
                                  32'(awaited.tx_ack_byte));
                end
                results_checked <= results_checked + 1;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else if (receiver_stall != 0) begin
                receiver_stall--;
                m_ready <= 1'b0;
            end else if (!steady && $urandom_range(0, 7) == 0) begin
                receiver_stall = $urandom_range(0, 5);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // one long receiver hold-off so the block backs up into its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && results_checked >= 160) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // run limit
    initial begin
        #400000;
        $display("link_arq_sequence_controller_tb failed");
        $finish;
    end

    // stimulus phases
    initial begin
        for (int i = 0; i < PEER_COUNT; i++) begin
            rx_next[i] = '0;
            place[i] = '0;
            send_end[i] = '0;
            err_tag[i] = '0;
            fixed_tag[i] = '0;
            resend[i] = '0;
            last_sent[i] = '0;
            gen_expected[i] = '0;
            gen_resend[i] = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed words at reset settings
        push_plain(ACT_SEND, 4'd0, 32'd0);
        push_plain(ACT_SEND, 4'd0, 32'd10);
        push_header(4'd0, 11'd5, 1'b1, 8'd0, 8'h00, 8'd0, 11'd0);      // minimum single
        push_header(4'd15, 11'd7, 1'b1, 8'd0, 8'h80, 8'd0, 11'd0);     // minimum double
        push_header(4'd15, 11'd20, 1'b1, 8'd1, 8'h80, 8'd0, 11'd6);    // second half only
        push_header(4'd0, 11'd40, 1'b1, 8'd0, 8'h00, 8'd0, 11'd0);     // duplicate
        push_header(4'd0, 11'd40, 1'b1, 8'd100, 8'h00, 8'd0, 11'd0);   // stale
        push_header(4'd0, 11'd40, 1'b0, 8'd1, 8'h18, 8'd0, 11'd0);     // crc failure
        push_header(4'd0, 11'd4, 1'b1, 8'd1, 8'h00, 8'd0, 11'd0);      // short frame
        push_header(4'd0, 11'd0, 1'b1, 8'd1, 8'h00, 8'd0, 11'd0);      // empty frame
        push_header(4'd0, 11'd12, 1'b1, 8'd1, 8'h80, 8'd0, 11'd10);    // impossible double
        push_header(4'd0, 11'd30, 1'b1, 8'd1, 8'h01, 8'd1, 11'd0);     // resend rewind
        push_plain(ACT_SEND, 4'd0, 32'd20);
        push_plain(ACT_TIMEOUT, 4'd1, 32'd5);                          // not yet due
        push_plain(ACT_SEND, 4'd2, 32'd100);
        push_plain(ACT_TIMEOUT, 4'd2, 32'd200);                        // due, rewinds
        push_plain(ACT_TIMEOUT, 4'd2, 32'd50);                         // clock behind send
        push_plain(ACT_TIMEOUT, 4'd3, 32'd1000);                       // due, backs off
        queue_request('1);                                             // unused action
        push_header(4'd15, 11'd2047, 1'b1, 8'hff, 8'hff, 8'hff, 11'd2047);
        push_plain(ACT_SEND, 4'd15, 32'hFFFF_FFFF);
        push_header(4'd1, 11'd2047, 1'b1, 8'd0, 8'h00, 8'd0, 11'd0);   // longest single
        push_header(4'd1, 11'd2047, 1'b1, 8'd1, 8'h80, 8'd0, 11'd2040);
        push_plain(ACT_TIMEOUT, 4'd0, 32'hFFFF_FFFF);
        wait_drained();

        // instant timeout, largest back-off, clock near wrap
        write_register(CFG_TIMEOUT_TICKS, 16'd0);
        write_register(CFG_RESEND_STEP_TICKS, 16'hFFFF);
        gen_now = 32'hFFFF_FF00;
        run_phase(100);

        // longest timeout, no back-off step
        write_register(CFG_TIMEOUT_TICKS, 16'hFFFF);
        write_register(CFG_RESEND_STEP_TICKS, 16'd0);
        run_phase(100);

        // random settings
        write_register(CFG_TIMEOUT_TICKS, 16'($urandom_range(0, 200)));
        write_register(CFG_RESEND_STEP_TICKS, 16'($urandom_range(0, 65535)));
        run_phase(100);

        // closing stretch with no idling on either side
        steady = 1'b1;
        write_register(CFG_TIMEOUT_TICKS, 16'($urandom_range(0, 100)));
        write_register(CFG_RESEND_STEP_TICKS, 16'($urandom_range(0, 65535)));
        run_phase(80);
        repeat (8) @(posedge aclk);

        if (awaited_results.size() != 0)
            report_mismatch("results never delivered", awaited_results.size(), 0);
        if (mismatch_count == 0)
            $display("link_arq_sequence_controller_tb passed");
        else
            $display("link_arq_sequence_controller_tb failed");
        $finish;
    end

endmodule

// File: link_arq_sequence_controller.f
sv/lasc_pkg.sv
sv/link_arq_sequence_controller.sv
sv/lasc_checker.sv
sim/link_arq_sequence_controller_tb.sv
